/* sv/assert_macros.svh */
// assertion macros shared by the rtl
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define QTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property must never hold
`define QTC_NEVER(lbl, prop, msg) \
  `QTC_ASSERT(lbl, !(prop), msg)

`endif

/* sv/qtc_pkg.sv */
// types and constants for the quintic trajectory coefficient block
// no dependencies
package qtc_pkg;

  localparam int DW     = 32;
  localparam int FB     = 16;
  localparam int TW     = 8 + FB;
  localparam int NW     = 88;
  localparam int T2W    = 2 * TW;
  localparam int T3W    = 3 * TW;
  localparam int T4W    = 4 * TW;
  localparam int T5W    = 5 * TW;
  localparam int RW     = T5W + 1;
  localparam int QB     = DW + 2;
  localparam int AW     = NW + 3 * FB;
  localparam int LANES  = 3;
  localparam int PRE    = 9;
  localparam int LAT    = PRE + QB + 1;
  localparam int SIDE_N = PRE + QB - 1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DW-1:0] start_position;
    logic signed [DW-1:0] start_velocity;
    logic signed [DW-1:0] start_acceleration;
    logic signed [DW-1:0] end_position;
    logic signed [DW-1:0] end_velocity;
    logic signed [DW-1:0] end_acceleration;
    logic [TW-1:0]        duration;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] coef0;
    logic signed [DW-1:0] coef1;
    logic signed [DW-1:0] coef2;
    logic signed [DW-1:0] coef3;
    logic signed [DW-1:0] coef4;
    logic signed [DW-1:0] coef5;
    status_e              status;
  } res_t;

  typedef struct packed {
    logic signed [DW-1:0] coef0;
    logic signed [DW-1:0] coef1;
    logic signed [DW-1:0] coef2;
    logic                 zero;
  } side_t;

endpackage

/* sv/quintic_trajectory_coefficients.sv */
// quintic trajectory coefficient pipeline, top level
// depends on qtc_pkg and assert_macros.svh
//
// A request beat is taken at a clock edge with start_i high and busy_o low;
// busy_o stays low, so a new request may enter every cycle.
// req_i carries start and end position, velocity, acceleration (Q16.16)
// and the duration T (Q8.16). Each request gives exactly one result beat on
// res_o, marked by done_o for one cycle.
// Results leave in request order, one per cycle at most.
// The latency is set by the 34-stage restoring divider (one quotient bit
// per stage, three lanes side by side for the cubic, quartic and quintic
// terms) behind 9 stages of products and sums, plus one rounding stage.
// status is ok, saturated (some coefficient clamped) or zero duration
// (higher coefficients forced to zero).
// Reset clears the valid bits of every stage; beats in flight are dropped.
// The receiver cannot stall: a result is on res_o for one cycle only.
`include "assert_macros.svh"

module quintic_trajectory_coefficients (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  qtc_pkg::req_t req_i,
  output logic          done_o,
  output qtc_pkg::res_t res_o
);

  logic accept;
  logic [qtc_pkg::LAT-1:0] v_q;

  qtc_pkg::req_t in0_q;
  qtc_pkg::side_t side_q [qtc_pkg::SIDE_N];

  // stage 1
  logic signed [qtc_pkg::DW:0]       s1_dp_q, s1_dv_q, s1_fn_q;
  logic signed [qtc_pkg::DW-1:0]     s1_as_q;
  logic [qtc_pkg::TW-1:0]            s1_t_q;
  logic [qtc_pkg::T2W-1:0]           s1_t2_q;
  logic signed [qtc_pkg::DW+qtc_pkg::TW:0] s1_vt_q;
  // stage 2
  logic signed [qtc_pkg::DW+qtc_pkg::TW+1:0] s2_dvt_q, s2_ft2l_q, s2_ft2h_q;
  logic signed [qtc_pkg::DW+qtc_pkg::TW:0]   s2_at2l_q, s2_at2h_q, s2_vt_q;
  logic signed [qtc_pkg::DW:0]        s2_dp_q;
  logic [qtc_pkg::T2W-1:0]            s2_t3l_q, s2_t3h_q;
  logic [qtc_pkg::TW-1:0]             s2_t_q;
  // stage 3
  logic signed [qtc_pkg::NW-1:0]      s3_at2_q, s3_ft2_q;
  logic signed [qtc_pkg::DW+qtc_pkg::TW+1:0] s3_dvt_q;
  logic signed [qtc_pkg::DW+qtc_pkg::TW:0]   s3_vt_q;
  logic signed [qtc_pkg::DW:0]        s3_dp_q;
  logic [qtc_pkg::T3W-1:0]            s3_t3_q;
  logic [qtc_pkg::TW-1:0]             s3_t_q;
  // stage 4
  logic signed [qtc_pkg::NW-1:0]      s4_dn_q, s4_et_q, s4_ft2_q;
  logic [qtc_pkg::T2W-1:0]            s4_t4p_q [3];
  logic [qtc_pkg::T3W-1:0]            s4_t3_q;
  logic [qtc_pkg::TW-1:0]             s4_t_q;
  // stage 5
  logic signed [qtc_pkg::NW-1:0]      s5_a_q [qtc_pkg::LANES];
  logic signed [qtc_pkg::NW-1:0]      s5_b_q [qtc_pkg::LANES];
  logic [qtc_pkg::T4W-1:0]            s5_t4_q;
  logic [qtc_pkg::T3W-1:0]            s5_t3_q;
  logic [qtc_pkg::TW-1:0]             s5_t_q;
  // stage 6
  logic signed [qtc_pkg::NW-1:0]      s6_n_q [qtc_pkg::LANES];
  logic [qtc_pkg::T2W-1:0]            s6_t5p_q [4];
  logic [qtc_pkg::T4W-1:0]            s6_t4_q;
  logic [qtc_pkg::T3W-1:0]            s6_t3_q;
  // stage 7
  logic                               s7_neg_q [qtc_pkg::LANES];
  logic [qtc_pkg::NW-1:0]             s7_mag_q [qtc_pkg::LANES];
  logic [qtc_pkg::RW-1:0]             s7_d_q   [qtc_pkg::LANES];
  // divider, index 0 is stage 8
  logic [qtc_pkg::RW-1:0] dr_q   [qtc_pkg::QB+1][qtc_pkg::LANES];
  logic [qtc_pkg::RW-1:0] dd_q   [qtc_pkg::QB+1][qtc_pkg::LANES];
  logic [qtc_pkg::QB-1:0] dq_q   [qtc_pkg::QB+1][qtc_pkg::LANES];
  logic [qtc_pkg::QB-1:0] dl_q   [qtc_pkg::QB][qtc_pkg::LANES];
  logic                   dneg_q [qtc_pkg::QB+1][qtc_pkg::LANES];
  logic                   dovf_q [qtc_pkg::QB+1][qtc_pkg::LANES];

  logic [qtc_pkg::RW-1:0] dr_d [qtc_pkg::QB][qtc_pkg::LANES];
  logic [qtc_pkg::QB-1:0] dq_d [qtc_pkg::QB][qtc_pkg::LANES];

  logic [qtc_pkg::RW-1:0] r0_d  [qtc_pkg::LANES];
  logic [qtc_pkg::QB-1:0] l0_d  [qtc_pkg::LANES];
  logic                   ov0_d [qtc_pkg::LANES];

  logic signed [qtc_pkg::DW-1:0] coef_d [qtc_pkg::LANES];
  logic [qtc_pkg::LANES-1:0]     sat_d;
  qtc_pkg::res_t res_d, res_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign done_o = v_q[qtc_pkg::LAT-1];
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[qtc_pkg::LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    in0_q <= req_i;

    // differences, t^2, v0*t
    s1_dp_q <= {in0_q.end_position[qtc_pkg::DW-1], in0_q.end_position}
             - {in0_q.start_position[qtc_pkg::DW-1], in0_q.start_position};
    s1_dv_q <= {in0_q.end_velocity[qtc_pkg::DW-1], in0_q.end_velocity}
             - {in0_q.start_velocity[qtc_pkg::DW-1], in0_q.start_velocity};
    s1_fn_q <= {in0_q.end_acceleration[qtc_pkg::DW-1], in0_q.end_acceleration}
             - {in0_q.start_acceleration[qtc_pkg::DW-1], in0_q.start_acceleration};
    s1_as_q <= in0_q.start_acceleration;
    s1_t_q  <= in0_q.duration;
    s1_t2_q <= in0_q.duration * in0_q.duration;
    s1_vt_q <= in0_q.start_velocity * $signed({1'b0, in0_q.duration});

    side_q[0].coef0 <= in0_q.start_position;
    side_q[0].coef1 <= in0_q.start_velocity;
    side_q[0].coef2 <= (in0_q.start_acceleration >>> 1)
                     + $signed(qtc_pkg::DW'(in0_q.start_acceleration[0]
                                            & ~in0_q.start_acceleration[qtc_pkg::DW-1]));
    side_q[0].zero  <= (in0_q.duration == '0);
    for (int i = 1; i < qtc_pkg::SIDE_N; i++) begin
      side_q[i] <= side_q[i-1];
    end

    // partial products
    s2_dvt_q  <= s1_dv_q * $signed({1'b0, s1_t_q});
    s2_at2l_q <= s1_as_q * $signed({1'b0, s1_t2_q[qtc_pkg::TW-1:0]});
    s2_at2h_q <= s1_as_q * $signed({1'b0, s1_t2_q[qtc_pkg::T2W-1:qtc_pkg::TW]});
    s2_ft2l_q <= s1_fn_q * $signed({1'b0, s1_t2_q[qtc_pkg::TW-1:0]});
    s2_ft2h_q <= s1_fn_q * $signed({1'b0, s1_t2_q[qtc_pkg::T2W-1:qtc_pkg::TW]});
    s2_t3l_q  <= s1_t2_q[qtc_pkg::TW-1:0] * s1_t_q;
    s2_t3h_q  <= s1_t2_q[qtc_pkg::T2W-1:qtc_pkg::TW] * s1_t_q;
    s2_dp_q   <= s1_dp_q;
    s2_vt_q   <= s1_vt_q;
    s2_t_q    <= s1_t_q;

    // a0*t^2, F*t^2, t^3
    s3_at2_q <= (qtc_pkg::NW'(s2_at2h_q) <<< qtc_pkg::TW) + qtc_pkg::NW'(s2_at2l_q);
    s3_ft2_q <= (qtc_pkg::NW'(s2_ft2h_q) <<< qtc_pkg::TW) + qtc_pkg::NW'(s2_ft2l_q);
    s3_t3_q  <= (qtc_pkg::T3W'(s2_t3h_q) << qtc_pkg::TW) + qtc_pkg::T3W'(s2_t3l_q);
    s3_dvt_q <= s2_dvt_q;
    s3_vt_q  <= s2_vt_q;
    s3_dp_q  <= s2_dp_q;
    s3_t_q   <= s2_t_q;

    // D and E*T numerators
    s4_dn_q  <= (qtc_pkg::NW'(s3_dp_q) <<< (2 * qtc_pkg::FB + 1))
              - (qtc_pkg::NW'(s3_vt_q) <<< (qtc_pkg::FB + 1)) - s3_at2_q;
    s4_et_q  <= (qtc_pkg::NW'(s3_dvt_q) <<< qtc_pkg::FB) - s3_at2_q;
    s4_ft2_q <= s3_ft2_q;
    for (int j = 0; j < 3; j++) begin
      s4_t4p_q[j] <= s3_t3_q[j*qtc_pkg::TW +: qtc_pkg::TW] * s3_t_q;
    end
    s4_t3_q <= s3_t3_q;
    s4_t_q  <= s3_t_q;

    // weighted terms
    s5_a_q[0] <= (s4_dn_q <<< 3) + (s4_dn_q <<< 1) + s4_ft2_q;
    s5_b_q[0] <= s4_et_q <<< 3;
    s5_a_q[1] <= (s4_et_q <<< 4) - (s4_et_q <<< 1);
    s5_b_q[1] <= (s4_dn_q <<< 4) - s4_dn_q + (s4_ft2_q <<< 1);
    s5_a_q[2] <= (s4_dn_q <<< 2) + (s4_dn_q <<< 1) + s4_ft2_q;
    s5_b_q[2] <= (s4_et_q <<< 2) + (s4_et_q <<< 1);
    s5_t4_q   <= (qtc_pkg::T4W'(s4_t4p_q[2]) << (2 * qtc_pkg::TW))
               + (qtc_pkg::T4W'(s4_t4p_q[1]) << qtc_pkg::TW)
               + qtc_pkg::T4W'(s4_t4p_q[0]);
    s5_t3_q   <= s4_t3_q;
    s5_t_q    <= s4_t_q;

    for (int j = 0; j < qtc_pkg::LANES; j++) begin
      s6_n_q[j] <= s5_a_q[j] - s5_b_q[j];
    end
    for (int j = 0; j < 4; j++) begin
      s6_t5p_q[j] <= s5_t4_q[j*qtc_pkg::TW +: qtc_pkg::TW] * s5_t_q;
    end
    s6_t4_q <= s5_t4_q;
    s6_t3_q <= s5_t3_q;

    // magnitudes and divisors
    for (int j = 0; j < qtc_pkg::LANES; j++) begin
      s7_neg_q[j] <= s6_n_q[j][qtc_pkg::NW-1];
      s7_mag_q[j] <= s6_n_q[j][qtc_pkg::NW-1] ? qtc_pkg::NW'(-s6_n_q[j])
                                             : qtc_pkg::NW'(s6_n_q[j]);
    end
    s7_d_q[0] <= qtc_pkg::RW'(s6_t3_q);
    s7_d_q[1] <= qtc_pkg::RW'(s6_t4_q);
    s7_d_q[2] <= (qtc_pkg::RW'(s6_t5p_q[3]) << (3 * qtc_pkg::TW))
               + (qtc_pkg::RW'(s6_t5p_q[2]) << (2 * qtc_pkg::TW))
               + (qtc_pkg::RW'(s6_t5p_q[1]) << qtc_pkg::TW)
               + qtc_pkg::RW'(s6_t5p_q[0]);

    // divider entry
    for (int j = 0; j < qtc_pkg::LANES; j++) begin
      dr_q[0][j]   <= r0_d[j];
      dl_q[0][j]   <= l0_d[j];
      dd_q[0][j]   <= s7_d_q[j];
      dq_q[0][j]   <= '0;
      dneg_q[0][j] <= s7_neg_q[j];
      dovf_q[0][j] <= ov0_d[j];
    end

    for (int k = 0; k < qtc_pkg::QB; k++) begin
      for (int j = 0; j < qtc_pkg::LANES; j++) begin
        dr_q[k+1][j]   <= dr_d[k][j];
        dq_q[k+1][j]   <= dq_d[k][j];
        dd_q[k+1][j]   <= dd_q[k][j];
        dneg_q[k+1][j] <= dneg_q[k][j];
        dovf_q[k+1][j] <= dovf_q[k][j];
        if (k < qtc_pkg::QB - 1) begin
          dl_q[k+1][j] <= dl_q[k][j] << 1;
        end
      end
    end

    res_q <= res_d;
  end

  // dividend |n| shifted by FB*(lane+1); split into start remainder and low bits
  always_comb begin
    logic [qtc_pkg::AW-1:0] a;
    for (int j = 0; j < qtc_pkg::LANES; j++) begin
      a      = qtc_pkg::AW'(s7_mag_q[j]) << (qtc_pkg::FB * (j + 1));
      r0_d[j]  = qtc_pkg::RW'(a[qtc_pkg::AW-1:qtc_pkg::QB]);
      l0_d[j]  = a[qtc_pkg::QB-1:0];
      ov0_d[j] = (qtc_pkg::RW'(a[qtc_pkg::AW-1:qtc_pkg::QB]) >= s7_d_q[j]);
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    logic [qtc_pkg::RW-1:0] rs;
    logic                   ge;
    for (int k = 0; k < qtc_pkg::QB; k++) begin
      for (int j = 0; j < qtc_pkg::LANES; j++) begin
        rs         = {dr_q[k][j][qtc_pkg::RW-2:0], dl_q[k][j][qtc_pkg::QB-1]};
        ge         = (rs >= dd_q[k][j]);
        dr_d[k][j] = ge ? rs - dd_q[k][j] : rs;
        dq_d[k][j] = {dq_q[k][j][qtc_pkg::QB-2:0], ge};
      end
    end
  end

  // round half away, clamp, restore sign
  always_comb begin
    logic [qtc_pkg::QB:0]   inc;
    logic [qtc_pkg::QB-1:0] qr, lim, val;
    for (int j = 0; j < qtc_pkg::LANES; j++) begin
      inc      = {1'b0, dq_q[qtc_pkg::QB][j]} + 1'b1;
      qr       = inc[qtc_pkg::QB:1];
      lim      = (qtc_pkg::QB'(1) << (qtc_pkg::DW - 1))
               - qtc_pkg::QB'(!dneg_q[qtc_pkg::QB][j]);
      sat_d[j] = dovf_q[qtc_pkg::QB][j] | (qr > lim);
      val      = sat_d[j] ? lim : qr;
      coef_d[j] = dneg_q[qtc_pkg::QB][j] ? -val[qtc_pkg::DW-1:0] : val[qtc_pkg::DW-1:0];
    end

    res_d.coef0 = side_q[qtc_pkg::SIDE_N-1].coef0;
    res_d.coef1 = side_q[qtc_pkg::SIDE_N-1].coef1;
    res_d.coef2 = side_q[qtc_pkg::SIDE_N-1].coef2;
    if (side_q[qtc_pkg::SIDE_N-1].zero) begin
      res_d.coef3  = '0;
      res_d.coef4  = '0;
      res_d.coef5  = '0;
      res_d.status = qtc_pkg::ST_ZERO;
    end else begin
      res_d.coef3  = coef_d[0];
      res_d.coef4  = coef_d[1];
      res_d.coef5  = coef_d[2];
      res_d.status = (|sat_d) ? qtc_pkg::ST_SAT : qtc_pkg::ST_OK;
    end
  end

  `QTC_ASSERT(a_lat_fwd, accept |-> ##(qtc_pkg::LAT) done_o,
              "request beat without result beat")
  `QTC_ASSERT(a_lat_back, done_o |-> $past(accept, qtc_pkg::LAT),
              "result beat without request beat")
  `QTC_NEVER(a_zero_coef, done_o && res_o.status == qtc_pkg::ST_ZERO &&
             (res_o.coef3 != '0 || res_o.coef4 != '0 || res_o.coef5 != '0),
             "zero duration with nonzero higher coefficient")
  `QTC_ASSERT(a_sat_limit, (done_o && res_o.status == qtc_pkg::ST_SAT) |->
              (res_o.coef3 == $signed({1'b1, {(qtc_pkg::DW-1){1'b0}}}) ||
               res_o.coef3 == $signed({1'b0, {(qtc_pkg::DW-1){1'b1}}}) ||
               res_o.coef4 == $signed({1'b1, {(qtc_pkg::DW-1){1'b0}}}) ||
               res_o.coef4 == $signed({1'b0, {(qtc_pkg::DW-1){1'b1}}}) ||
               res_o.coef5 == $signed({1'b1, {(qtc_pkg::DW-1){1'b0}}}) ||
               res_o.coef5 == $signed({1'b0, {(qtc_pkg::DW-1){1'b1}}})),
              "saturation flagged with no coefficient at a limit")
  `QTC_ASSERT(a_rem_bound, (v_q[qtc_pkg::LAT-2] && !side_q[qtc_pkg::SIDE_N-1].zero) |->
              ((dovf_q[qtc_pkg::QB][0] || dr_q[qtc_pkg::QB][0] < dd_q[qtc_pkg::QB][0]) &&
               (dovf_q[qtc_pkg::QB][1] || dr_q[qtc_pkg::QB][1] < dd_q[qtc_pkg::QB][1]) &&
               (dovf_q[qtc_pkg::QB][2] || dr_q[qtc_pkg::QB][2] < dd_q[qtc_pkg::QB][2])),
              "divider remainder not below divisor")

endmodule
